>>> rtl/tgr_pkg.sv
// shared types, codes and reset values for the tilt gesture recognizer
package tgr_pkg;

	localparam int AXIS_W   = 16;
	localparam int LEVEL_W  = 15;
	localparam int TIME_W   = 32;
	localparam int CODE_W   = 3;
	localparam int LED_W    = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// orientation and event codes share one encoding
	localparam logic [CODE_W-1:0] ORI_UP      = 3'd0;
	localparam logic [CODE_W-1:0] ORI_DOWN    = 3'd1;
	localparam logic [CODE_W-1:0] ORI_LEFT    = 3'd2;
	localparam logic [CODE_W-1:0] ORI_RIGHT   = 3'd3;
	localparam logic [CODE_W-1:0] EV_ENTER    = 3'd4;
	localparam logic [CODE_W-1:0] EV_EXIT     = 3'd5;
	localparam logic [CODE_W-1:0] ORI_NEUTRAL = 3'd6;
	localparam logic [CODE_W-1:0] ORI_OTHER   = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_QUIET_BAND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_SWITCH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_MAX   = 3'd4;

	localparam logic [LEVEL_W-1:0] QUIET_BAND_RST  = 15'd50;
	localparam logic [LEVEL_W-1:0] GRAVITY_RST     = 15'd100;
	localparam logic [TIME_W-1:0]  MODE_SWITCH_RST = 32'd2000000;
	localparam logic [TIME_W-1:0]  CLICK_MIN_RST   = 32'd1000000;
	localparam logic [TIME_W-1:0]  CLICK_MAX_RST   = 32'd2000000;

	localparam logic [LED_W-1:0] LED_CLICK = 5'h1f;
	localparam logic [LED_W-1:0] LED_SHORT = 5'h04;
	localparam logic [LED_W-1:0] LED_READY = 5'h15;
	localparam logic [LED_W-1:0] LED_OFF   = 5'h00;

	typedef struct packed {
		logic [TIME_W-1:0] mode_switch_time;
		logic [TIME_W-1:0] click_min_time;
		logic [TIME_W-1:0] click_max_time;
	} tgr_timing_t;

	typedef struct packed {
		logic              event_valid;
		logic [CODE_W-1:0] event_code;
		logic              led_valid;
		logic [LED_W-1:0]  led_pattern;
	} tgr_res_t;

endpackage

>>> rtl/tgr_classify.sv
// orientation classifier from one accelerometer sample
module tgr_classify (
	input  logic signed [tgr_pkg::AXIS_W-1:0]  accel_x,
	input  logic signed [tgr_pkg::AXIS_W-1:0]  accel_y,
	input  logic signed [tgr_pkg::AXIS_W-1:0]  accel_z,
	input  logic        [tgr_pkg::LEVEL_W-1:0] quiet_band,
	input  logic        [tgr_pkg::LEVEL_W-1:0] gravity_level,
	output logic        [tgr_pkg::CODE_W-1:0]  orientation
);

	// one extra bit so that minus the level always fits
	logic signed [tgr_pkg::AXIS_W:0] x_ext, y_ext, z_ext;
	logic signed [tgr_pkg::AXIS_W:0] q_pos, q_neg, g_pos, g_neg;
	logic qx, qy, qz;

	assign x_ext = {accel_x[tgr_pkg::AXIS_W-1], accel_x};
	assign y_ext = {accel_y[tgr_pkg::AXIS_W-1], accel_y};
	assign z_ext = {accel_z[tgr_pkg::AXIS_W-1], accel_z};
	assign q_pos = $signed({2'b00, quiet_band});
	assign q_neg = -q_pos;
	assign g_pos = $signed({2'b00, gravity_level});
	assign g_neg = -g_pos;

	assign qx = (x_ext > q_neg) && (x_ext < q_pos);
	assign qy = (y_ext > q_neg) && (y_ext < q_pos);
	assign qz = (z_ext > q_neg) && (z_ext < q_pos);

	always_comb begin
		if (qx && qy && (z_ext > g_pos)) begin
			orientation = tgr_pkg::ORI_NEUTRAL;
		end else if (qx && qz && (y_ext < g_neg)) begin
			orientation = tgr_pkg::ORI_UP;
		end else if (qx && qz && (y_ext > g_pos)) begin
			orientation = tgr_pkg::ORI_DOWN;
		end else if (qy && qz && (x_ext < g_neg)) begin
			orientation = tgr_pkg::ORI_LEFT;
		end else if (qy && qz && (x_ext > g_pos)) begin
			orientation = tgr_pkg::ORI_RIGHT;
		end else begin
			orientation = tgr_pkg::ORI_OTHER;
		end
	end

endmodule

>>> rtl/tgr_tracker.sv
// hold tracking, click and mode events, led feedback
module tgr_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [tgr_pkg::CODE_W-1:0]        orientation,
	input  logic [tgr_pkg::TIME_W-1:0]        now_us,
	input  tgr_pkg::tgr_timing_t              timing,
	output tgr_pkg::tgr_res_t                 res
);

	logic [tgr_pkg::CODE_W-1:0] held_q;
	logic [tgr_pkg::TIME_W-1:0] entry_time_q;
	logic [tgr_pkg::CODE_W-1:0] last_event_q;

	logic [tgr_pkg::TIME_W-1:0] dur;
	logic [tgr_pkg::CODE_W-1:0] last_next;
	logic ev, blink, known;
	logic [tgr_pkg::CODE_W-1:0] code;
	logic [tgr_pkg::LED_W-1:0]  pat;

	// elapsed time wraps with the free-running counter
	assign dur   = now_us - entry_time_q;
	assign known = (orientation != tgr_pkg::ORI_OTHER);

	always_comb begin
		ev    = 1'b0;
		blink = 1'b0;
		code  = tgr_pkg::ORI_UP;
		if (orientation == tgr_pkg::ORI_NEUTRAL) begin
			if (last_event_q == tgr_pkg::EV_ENTER) begin
				if (held_q == tgr_pkg::ORI_NEUTRAL && dur > timing.mode_switch_time) begin
					ev   = 1'b1;
					code = tgr_pkg::EV_EXIT;
				end
			end else if (held_q[tgr_pkg::CODE_W-1] == 1'b0) begin
				// release from a direction held inside the click window
				if (dur > timing.click_min_time && dur < timing.click_max_time) begin
					ev    = 1'b1;
					code  = held_q;
					blink = 1'b1;
				end
			end
		end else if (orientation == tgr_pkg::ORI_UP && held_q == tgr_pkg::ORI_UP) begin
			if (last_event_q != tgr_pkg::EV_ENTER && dur > timing.mode_switch_time) begin
				ev   = 1'b1;
				code = tgr_pkg::EV_ENTER;
			end
		end
	end

	assign last_next = ev ? code : last_event_q;

	always_comb begin
		if (blink) begin
			pat = tgr_pkg::LED_CLICK;
		end else if (orientation == tgr_pkg::ORI_NEUTRAL) begin
			pat = tgr_pkg::LED_OFF;
		end else if (dur < timing.click_min_time) begin
			pat = tgr_pkg::LED_SHORT;
		end else if (dur < timing.click_max_time) begin
			pat = tgr_pkg::LED_READY;
		end else begin
			pat = tgr_pkg::LED_OFF;
		end
	end

	always_comb begin
		res.event_valid = known && ev;
		res.event_code  = (known && ev) ? code : '0;
		res.led_valid   = known && (last_next != tgr_pkg::EV_ENTER);
		res.led_pattern = (known && (last_next != tgr_pkg::EV_ENTER)) ? pat : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= tgr_pkg::ORI_OTHER;
			entry_time_q <= '0;
			last_event_q <= tgr_pkg::ORI_NEUTRAL;
		end else if (step && known) begin
			last_event_q <= last_next;
			if (orientation != held_q) begin
				held_q       <= orientation;
				entry_time_q <= now_us;
			end
		end
	end

endmodule

>>> rtl/tilt_gesture_recognizer_core.sv
// top level: config registers, sample register, result register and handshake
// a word accepted into the sample register passes through the classifier and tracker into the result register
// throughput: one word per cycle while the output is not stalled; the hold state is
//   read and written as a word moves from the sample register to the result register
// a stalled output holds its word and backs up into the sample register
// reset: asynchronous, active low; config returns to defaults, hold state to
//   "other", entry time to zero, last event to neutral, both stages empty
module tilt_gesture_recognizer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [tgr_pkg::AXIS_W-1:0]    accel_x,
	input  logic signed [tgr_pkg::AXIS_W-1:0]    accel_y,
	input  logic signed [tgr_pkg::AXIS_W-1:0]    accel_z,
	input  logic        [tgr_pkg::TIME_W-1:0]    now_us,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 event_valid,
	output logic        [tgr_pkg::CODE_W-1:0]    event_code,
	output logic                                 led_valid,
	output logic        [tgr_pkg::LED_W-1:0]     led_pattern,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [tgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [tgr_pkg::CFG_DAT_W-1:0] cfg_data
);

	logic [tgr_pkg::LEVEL_W-1:0] quiet_band_q;
	logic [tgr_pkg::LEVEL_W-1:0] gravity_q;
	tgr_pkg::tgr_timing_t        timing_q;

	logic                               valid_s1;
	logic signed [tgr_pkg::AXIS_W-1:0]  x_s1, y_s1, z_s1;
	logic        [tgr_pkg::TIME_W-1:0]  now_s1;

	logic              out_valid_q;
	tgr_pkg::tgr_res_t res_q;
	tgr_pkg::tgr_res_t res;

	logic out_free, s1_fire, in_acc;
	logic [tgr_pkg::CODE_W-1:0] orientation;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_band_q              <= tgr_pkg::QUIET_BAND_RST;
			gravity_q                 <= tgr_pkg::GRAVITY_RST;
			timing_q.mode_switch_time <= tgr_pkg::MODE_SWITCH_RST;
			timing_q.click_min_time   <= tgr_pkg::CLICK_MIN_RST;
			timing_q.click_max_time   <= tgr_pkg::CLICK_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tgr_pkg::REG_QUIET_BAND: begin
					quiet_band_q <= cfg_data[tgr_pkg::LEVEL_W-1:0];
				end
				tgr_pkg::REG_GRAVITY: begin
					gravity_q <= cfg_data[tgr_pkg::LEVEL_W-1:0];
				end
				tgr_pkg::REG_MODE_SWITCH: begin
					timing_q.mode_switch_time <= cfg_data;
				end
				tgr_pkg::REG_CLICK_MIN: begin
					timing_q.click_min_time <= cfg_data;
				end
				tgr_pkg::REG_CLICK_MAX: begin
					timing_q.click_max_time <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// handshake: the sample register moves on whenever the result register is free
	assign out_free = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1   <= accel_x;
			y_s1   <= accel_y;
			z_s1   <= accel_z;
			now_s1 <= now_us;
		end
	end

	tgr_classify u_classify (
		.accel_x       (x_s1),
		.accel_y       (y_s1),
		.accel_z       (z_s1),
		.quiet_band    (quiet_band_q),
		.gravity_level (gravity_q),
		.orientation   (orientation)
	);

	tgr_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_fire),
		.orientation (orientation),
		.now_us      (now_s1),
		.timing      (timing_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_valid = res_q.event_valid;
	assign event_code  = res_q.event_code;
	assign led_valid   = res_q.led_valid;
	assign led_pattern = res_q.led_pattern;

	// a blocked sample word waits in place
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(now_s1) && $stable(x_s1))
		else $error("sample word lost while output blocked");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with free pipeline");

	a_no_code_without_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.event_valid |-> res_q.event_code == '0)
		else $error("event code set without event");

	a_enter_mutes_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_valid && res_q.event_code == tgr_pkg::EV_ENTER
			|-> !res_q.led_valid)
		else $error("led painted on mode entry");

	a_click_blinks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_valid && !res_q.event_code[tgr_pkg::CODE_W-1]
			|-> res_q.led_valid && res_q.led_pattern == tgr_pkg::LED_CLICK)
		else $error("click without full led pattern");

endmodule
